// File: rtl/core/c6502x_pkg.sv
// ============================================================================
// c6502x_pkg
// Shared types, opcode numbering and flag constants for the 6502 execute block.
// ============================================================================
package c6502x_pkg;

    localparam int InBits  = 96;
    localparam int OutBits = 88;

    localparam logic [7:0] P_C = 8'h01;
    localparam logic [7:0] P_Z = 8'h02;
    localparam logic [7:0] P_I = 8'h04;
    localparam logic [7:0] P_D = 8'h08;
    localparam logic [7:0] P_B = 8'h10;
    localparam logic [7:0] P_U = 8'h20;
    localparam logic [7:0] P_V = 8'h40;
    localparam logic [7:0] P_N = 8'h80;

    localparam logic [7:0] SP_RESET = 8'hFD;
    localparam logic [7:0] P_RESET  = 8'h24;
    localparam logic [3:0] MODE_ACC = 4'd12;

    typedef enum logic [5:0] {
        OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_TAX, OP_TAY,
        OP_TXA, OP_TYA, OP_TSX, OP_TXS, OP_PHA, OP_PHP, OP_PLA, OP_PLP,
        OP_AND, OP_EOR, OP_ORA, OP_BIT, OP_ADC, OP_SBC, OP_CMP, OP_CPX,
        OP_CPY, OP_INC, OP_DEC, OP_INX, OP_INY, OP_DEX, OP_DEY, OP_ASL,
        OP_LSR, OP_ROL, OP_ROR, OP_JMP, OP_JSR, OP_RTS, OP_BCC, OP_BCS,
        OP_BEQ, OP_BNE, OP_BMI, OP_BPL, OP_BVS, OP_BVC, OP_CLC, OP_CLD,
        OP_CLI, OP_CLV, OP_SEC, OP_SED, OP_SEI, OP_NOP, OP_BRK, OP_RTI
    } op_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } regs_t;

    // One executed instruction: up to three writes plus final state
    typedef struct packed {
        logic [1:0]  wr_cnt;
        logic [15:0] wa0;
        logic [7:0]  wd0;
        logic [15:0] wa1;
        logic [7:0]  wd1;
        logic [15:0] wa2;
        logic [7:0]  wd2;
        logic [15:0] pc;
        regs_t       regs;
        logic        fault;
    } exec_t;

    // Legal addressing mode mask per action code
    function automatic logic [15:0] legal_modes(input logic [5:0] act);
        logic [15:0] m;
        case (act)
            6'd0, 6'd16, 6'd17, 6'd18, 6'd20, 6'd21, 6'd22: m = 16'h0377;
            6'd1:                m = 16'h005B;
            6'd2:                m = 16'h0037;
            6'd3:                m = 16'h0376;
            6'd4:                m = 16'h001A;
            6'd5:                m = 16'h0016;
            6'd19:               m = 16'h0012;
            6'd23, 6'd24:        m = 16'h0013;
            6'd25, 6'd26:        m = 16'h0036;
            6'd31, 6'd32, 6'd33, 6'd34: m = 16'h1036;
            6'd35:               m = 16'h0090;
            6'd36:               m = 16'h0010;
            6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45: m = 16'h0400;
            6'd56, 6'd57, 6'd58, 6'd59, 6'd60, 6'd61, 6'd62, 6'd63: m = 16'h0000;
            default:             m = 16'hFFFF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        return (p & ~(P_N | P_Z)) | (v & P_N) | ((v == 8'd0) ? P_Z : 8'd0);
    endfunction

endpackage

// File: rtl/core/c6502x_alu.sv
// ============================================================================
// c6502x_alu
// Combinational execute of one instruction against the current registers.
// ============================================================================
module c6502x_alu
    import c6502x_pkg::*;
(
    input  logic [5:0]  action,
    input  logic [3:0]  addressing_mode,
    input  logic [7:0]  operand_value,
    input  logic [15:0] operand_address,
    input  logic [15:0] next_pc,
    input  logic [7:0]  stack_byte_one,
    input  logic [7:0]  stack_byte_two,
    input  logic [7:0]  stack_byte_three,
    input  logic [15:0] vector_word,
    input  regs_t       cur,
    output exec_t       res
);

    logic        bad;
    logic [15:0] mask;
    logic [8:0]  sum;
    logic [7:0]  addend;
    logic [7:0]  cmp_r;
    logic [8:0]  cmp_d;
    logic [7:0]  sv;
    logic [7:0]  sr;
    logic        take;
    logic [15:0] ret;
    logic [7:0]  pb;
    logic [7:0]  sp1;
    logic [7:0]  sp2;
    logic [7:0]  sp3;

    always_comb begin
        mask = legal_modes(action);
        bad  = !mask[addressing_mode];
    end

    // Shared arithmetic
    always_comb begin
        addend = (action == OP_SBC) ? ~operand_value : operand_value;
        sum    = {1'b0, cur.a} + {1'b0, addend} + {8'd0, cur.p[0]};
        case (action)
            OP_CPX:  cmp_r = cur.x;
            OP_CPY:  cmp_r = cur.y;
            default: cmp_r = cur.a;
        endcase
        cmp_d = {1'b0, cmp_r} - {1'b0, operand_value};
        sv    = (addressing_mode == MODE_ACC) ? cur.a : operand_value;
        case (action)
            OP_ASL:  sr = {sv[6:0], 1'b0};
            OP_LSR:  sr = {1'b0, sv[7:1]};
            OP_ROL:  sr = {sv[6:0], cur.p[0]};
            default: sr = {cur.p[0], sv[7:1]};
        endcase
        pb  = cur.p | P_B | P_U;
        sp1 = cur.sp - 8'd1;
        sp2 = cur.sp - 8'd2;
        sp3 = cur.sp - 8'd3;
        ret = (action == OP_BRK) ? next_pc + 16'd1 : next_pc - 16'd1;
    end

    always_comb begin
        res       = '0;
        res.pc    = next_pc;
        res.regs  = cur;
        res.fault = bad;
        take      = 1'b0;
        if (!bad) begin
            case (action)
                OP_LDA: begin res.regs.a = operand_value; res.regs.p = set_nz(cur.p, operand_value); end
                OP_LDX: begin res.regs.x = operand_value; res.regs.p = set_nz(cur.p, operand_value); end
                OP_LDY: begin res.regs.y = operand_value; res.regs.p = set_nz(cur.p, operand_value); end
                OP_STA: begin res.wr_cnt = 2'd1; res.wa0 = operand_address; res.wd0 = cur.a; end
                OP_STX: begin res.wr_cnt = 2'd1; res.wa0 = operand_address; res.wd0 = cur.x; end
                OP_STY: begin res.wr_cnt = 2'd1; res.wa0 = operand_address; res.wd0 = cur.y; end
                OP_TAX: begin res.regs.x = cur.a; res.regs.p = set_nz(cur.p, cur.a); end
                OP_TAY: begin res.regs.y = cur.a; res.regs.p = set_nz(cur.p, cur.a); end
                OP_TXA: begin res.regs.a = cur.x; res.regs.p = set_nz(cur.p, cur.x); end
                OP_TYA: begin res.regs.a = cur.y; res.regs.p = set_nz(cur.p, cur.y); end
                OP_TSX: begin res.regs.x = cur.sp; res.regs.p = set_nz(cur.p, cur.sp); end
                OP_TXS: res.regs.sp = cur.x;
                OP_PHA: begin
                    res.wr_cnt = 2'd1; res.wa0 = {8'h01, cur.sp}; res.wd0 = cur.a;
                    res.regs.sp = sp1;
                end
                OP_PHP: begin
                    res.wr_cnt = 2'd1; res.wa0 = {8'h01, cur.sp}; res.wd0 = pb;
                    res.regs.sp = sp1;
                end
                OP_PLA: begin
                    res.regs.sp = cur.sp + 8'd1; res.regs.a = stack_byte_one;
                    res.regs.p = set_nz(cur.p, stack_byte_one);
                end
                OP_PLP: begin
                    res.regs.sp = cur.sp + 8'd1;
                    res.regs.p = (stack_byte_one & ~P_B) | P_U;
                end
                OP_AND: begin res.regs.a = cur.a & operand_value; res.regs.p = set_nz(cur.p, cur.a & operand_value); end
                OP_EOR: begin res.regs.a = cur.a ^ operand_value; res.regs.p = set_nz(cur.p, cur.a ^ operand_value); end
                OP_ORA: begin res.regs.a = cur.a | operand_value; res.regs.p = set_nz(cur.p, cur.a | operand_value); end
                OP_BIT: begin
                    res.regs.p = (cur.p & ~(P_N | P_V | P_Z)) | (operand_value & (P_N | P_V))
                               | (((operand_value & cur.a) == 8'd0) ? P_Z : 8'd0);
                end
                OP_ADC, OP_SBC: begin
                    res.regs.a = sum[7:0];
                    res.regs.p = set_nz(cur.p, sum[7:0]);
                    res.regs.p[0] = sum[8];
                    res.regs.p[6] = ~(cur.a[7] ^ addend[7]) & (cur.a[7] ^ sum[7]);
                end
                OP_CMP, OP_CPX, OP_CPY: begin
                    res.regs.p = set_nz(cur.p, cmp_d[7:0]);
                    res.regs.p[0] = ~cmp_d[8];
                end
                OP_INC: begin
                    res.wr_cnt = 2'd1; res.wa0 = operand_address; res.wd0 = operand_value + 8'd1;
                    res.regs.p = set_nz(cur.p, operand_value + 8'd1);
                end
                OP_DEC: begin
                    res.wr_cnt = 2'd1; res.wa0 = operand_address; res.wd0 = operand_value - 8'd1;
                    res.regs.p = set_nz(cur.p, operand_value - 8'd1);
                end
                OP_INX: begin res.regs.x = cur.x + 8'd1; res.regs.p = set_nz(cur.p, cur.x + 8'd1); end
                OP_INY: begin res.regs.y = cur.y + 8'd1; res.regs.p = set_nz(cur.p, cur.y + 8'd1); end
                OP_DEX: begin res.regs.x = cur.x - 8'd1; res.regs.p = set_nz(cur.p, cur.x - 8'd1); end
                OP_DEY: begin res.regs.y = cur.y - 8'd1; res.regs.p = set_nz(cur.p, cur.y - 8'd1); end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                    res.regs.p = set_nz(cur.p, sr);
                    res.regs.p[0] = (action == OP_ASL || action == OP_ROL) ? sv[7] : sv[0];
                    if (addressing_mode == MODE_ACC) begin
                        res.regs.a = sr;
                    end else begin
                        res.wr_cnt = 2'd1; res.wa0 = operand_address; res.wd0 = sr;
                    end
                end
                OP_JMP: res.pc = operand_address;
                OP_JSR: begin
                    res.wr_cnt = 2'd2;
                    res.wa0 = {8'h01, cur.sp}; res.wd0 = ret[15:8];
                    res.wa1 = {8'h01, sp1};    res.wd1 = ret[7:0];
                    res.regs.sp = sp2;
                    res.pc = operand_address;
                end
                OP_RTS: begin
                    res.regs.sp = cur.sp + 8'd2;
                    res.pc = {stack_byte_two, stack_byte_one} + 16'd1;
                end
                OP_BCC: take = !cur.p[0];
                OP_BCS: take = cur.p[0];
                OP_BEQ: take = cur.p[1];
                OP_BNE: take = !cur.p[1];
                OP_BMI: take = cur.p[7];
                OP_BPL: take = !cur.p[7];
                OP_BVS: take = cur.p[6];
                OP_BVC: take = !cur.p[6];
                OP_CLC: res.regs.p = cur.p & ~P_C;
                OP_CLD: res.regs.p = cur.p & ~P_D;
                OP_CLI: res.regs.p = cur.p & ~P_I;
                OP_CLV: res.regs.p = cur.p & ~P_V;
                OP_SEC: res.regs.p = cur.p | P_C;
                OP_SED: res.regs.p = cur.p | P_D;
                OP_SEI: res.regs.p = cur.p | P_I;
                OP_BRK: begin
                    res.wr_cnt = 2'd3;
                    res.wa0 = {8'h01, cur.sp}; res.wd0 = ret[15:8];
                    res.wa1 = {8'h01, sp1};    res.wd1 = ret[7:0];
                    res.wa2 = {8'h01, sp2};    res.wd2 = pb;
                    res.regs.sp = sp3;
                    res.regs.p = cur.p | P_I;
                    res.pc = vector_word;
                end
                OP_RTI: begin
                    res.regs.sp = cur.sp + 8'd3;
                    res.regs.p = (stack_byte_one & ~P_B) | P_U;
                    res.pc = {stack_byte_three, stack_byte_two};
                end
                default: ;
            endcase
            if (take) begin
                res.pc = next_pc + {{8{operand_value[7]}}, operand_value};
            end
        end
    end

endmodule

// File: rtl/core/c6502x_out.sv
// ============================================================================
// c6502x_out
// Result holding register; splits one instruction into its write transactions.
// ============================================================================
module c6502x_out
    import c6502x_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  exec_t              res_in,
    output logic               busy,
    output logic               done,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OutBits-1:0] m_axis_tdata,
    output logic               m_axis_tlast
);

    exec_t       hold_reg;
    logic        valid_reg;
    logic [1:0]  idx_reg;
    logic [1:0]  cnt;
    logic        is_last;
    logic        wv;
    logic [15:0] wa;
    logic [7:0]  wd;

    always_comb begin
        cnt     = (hold_reg.wr_cnt == 2'd0) ? 2'd1 : hold_reg.wr_cnt;
        is_last = (idx_reg == cnt - 2'd1);
        wv      = (hold_reg.wr_cnt != 2'd0);
        case (idx_reg)
            2'd0:    begin wa = hold_reg.wa0; wd = hold_reg.wd0; end
            2'd1:    begin wa = hold_reg.wa1; wd = hold_reg.wd1; end
            default: begin wa = hold_reg.wa2; wd = hold_reg.wd2; end
        endcase
        if (!wv) begin
            wa = 16'd0;
            wd = 8'd0;
        end
        done = valid_reg && m_axis_tready && is_last;
        busy = valid_reg && !done;
    end

    // Walk the write list, then take the next instruction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (done) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_axis_tready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hold_reg <= res_in;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = is_last;
    assign m_axis_tdata  = {6'd0, hold_reg.fault, hold_reg.regs.p, hold_reg.regs.sp,
                            hold_reg.regs.y, hold_reg.regs.x, hold_reg.regs.a,
                            hold_reg.pc, wd, wa, wv};

endmodule

// File: rtl/core/cpu_6502_instruction_execute_top.sv
// ============================================================================
// cpu_6502_instruction_execute_top
// 6502 execute stage, no decimal mode: execute logic, architectural register set, result stage.
// ============================================================================
// Channel  Dir  Fields (tdata, low bit first)
// s_axis   in   action, addressing_mode, operand_value, operand_address, next_pc,
//               stack_byte_one, stack_byte_two, stack_byte_three, vector_word
// m_axis   out  write_valid, write_address, write_data, new_pc, reg_a..reg_p,
//               fault; tlast = last
// One output transaction per memory write (at least one), so an instruction
// yields one to three transactions at the output; a new instruction is taken in the cycle
// its predecessor's last transaction leaves. The architectural registers sit
// in one register set updated on acceptance. Reset: A=X=Y=0, SP=0xFD, P=0x24.
// Output stalls hold the result stage and, through it, the input.
module cpu_6502_instruction_execute_top
    import c6502x_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [InBits-1:0]  s_axis_tdata,   // see table above
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OutBits-1:0] m_axis_tdata,   // see table above
    output logic               m_axis_tlast
);

    regs_t cur_reg;
    exec_t res;
    logic  busy;
    logic  done;
    logic  load;

    assign s_axis_tready = !busy;
    assign load          = s_axis_tvalid && s_axis_tready;

    c6502x_alu u_alu (
        .action           (s_axis_tdata[5:0]),
        .addressing_mode  (s_axis_tdata[9:6]),
        .operand_value    (s_axis_tdata[17:10]),
        .operand_address  (s_axis_tdata[33:18]),
        .next_pc          (s_axis_tdata[49:34]),
        .stack_byte_one   (s_axis_tdata[57:50]),
        .stack_byte_two   (s_axis_tdata[65:58]),
        .stack_byte_three (s_axis_tdata[73:66]),
        .vector_word      (s_axis_tdata[89:74]),
        .cur              (cur_reg),
        .res              (res)
    );

    // Architectural register set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, p: P_RESET};
        end else if (load) begin
            cur_reg <= res.regs;
        end
    end

    c6502x_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .res_in        (res),
        .busy          (busy),
        .done          (done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: rtl/core/c6502x_chk.sv
// ============================================================================
// c6502x_chk
// Port-level checks on the execute block, bound to the top level.
// ============================================================================
module c6502x_chk
    import c6502x_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [OutBits-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No input taken mid-instruction
    a_noin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !(m_axis_tready && m_axis_tlast) |-> !s_axis_tready)
        else $error("input accepted during an instruction");

    // A fault never carries a write and is always last
    a_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[81] |-> m_axis_tlast && !m_axis_tdata[0])
        else $error("fault with write");

    // Accepted input yields a result next cycle
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after input");

endmodule

bind cpu_6502_instruction_execute_top c6502x_chk u_chk (.*);

// File: tb/sv/tb_cpu_6502_instruction_execute_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_cpu_6502_instruction_execute_top
// Drives single decoded 6502 instructions into the execute stage and compares
// every write transaction and the final register state with a local model.
// ============================================================================
import c6502x_pkg::*;

typedef struct packed {
    logic        wv;
    logic [15:0] wa;
    logic [7:0]  wd;
    logic        last;
    logic [15:0] pc;
    logic [7:0]  a, x, y, sp, p;
    logic        fault;
} exec_result_t;

class exec_scoreboard;
    logic [7:0] a, x, y, sp, p;
    exec_result_t pending[$];
    int errors;

    function new();
        a = 0; x = 0; y = 0; sp = SP_RESET; p = P_RESET; errors = 0;
    endfunction

    function logic [15:0] mode_mask(logic [5:0] act);
        case (act)
            OP_LDA, OP_AND, OP_EOR, OP_ORA, OP_ADC, OP_SBC, OP_CMP: return 16'h0377;
            OP_LDX: return 16'h005B;
            OP_LDY: return 16'h0037;
            OP_STA: return 16'h0376;
            OP_STX: return 16'h001A;
            OP_STY: return 16'h0016;
            OP_BIT: return 16'h0012;
            OP_CPX, OP_CPY: return 16'h0013;
            OP_INC, OP_DEC: return 16'h0036;
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: return 16'h1036;
            OP_JMP: return 16'h0090;
            OP_JSR: return 16'h0010;
            OP_BCC, OP_BCS, OP_BEQ, OP_BNE, OP_BMI, OP_BPL, OP_BVS, OP_BVC:
                return 16'h0400;
            default: return (act > OP_RTI) ? 16'h0000 : 16'hFFFF;
        endcase
    endfunction

    function logic [7:0] nz(logic [7:0] f, logic [7:0] v);
        return (f & ~(P_N | P_Z)) | (v & P_N) | ((v == 0) ? P_Z : 8'h00);
    endfunction

    function logic [7:0] cmpf(logic [7:0] f, logic [7:0] r, logic [7:0] m);
        f = (r >= m) ? (f | P_C) : (f & ~P_C);
        return nz(f, r - m);
    endfunction

    // Predicts the transactions of one accepted instruction
    function void note_instruction(logic [InBits-1:0] d);
        logic [5:0] act; logic [3:0] mode; logic [7:0] m, s1, s2, s3, v, r;
        logic [15:0] ea, pc, vec, ret, mm; logic [8:0] sum; logic bad, take;
        logic [15:0] wa[3]; logic [7:0] wd[3]; int n, k;
        exec_result_t e;
        act = d[5:0]; mode = d[9:6]; m = d[17:10]; ea = d[33:18]; pc = d[49:34];
        s1 = d[57:50]; s2 = d[65:58]; s3 = d[73:66]; vec = d[89:74];
        mm = mode_mask(act);
        bad = !mm[mode]; take = 0; n = 0;
        if (!bad) begin
            case (act)
                OP_LDA: begin a = m; p = nz(p, a); end
                OP_LDX: begin x = m; p = nz(p, x); end
                OP_LDY: begin y = m; p = nz(p, y); end
                OP_STA: begin wa[n] = ea; wd[n] = a; n++; end
                OP_STX: begin wa[n] = ea; wd[n] = x; n++; end
                OP_STY: begin wa[n] = ea; wd[n] = y; n++; end
                OP_TAX: begin x = a; p = nz(p, x); end
                OP_TAY: begin y = a; p = nz(p, y); end
                OP_TXA: begin a = x; p = nz(p, a); end
                OP_TYA: begin a = y; p = nz(p, a); end
                OP_TSX: begin x = sp; p = nz(p, x); end
                OP_TXS: sp = x;
                OP_PHA: begin wa[n] = {8'h01, sp}; wd[n] = a; n++; sp--; end
                OP_PHP: begin wa[n] = {8'h01, sp}; wd[n] = p | P_B | P_U; n++; sp--; end
                OP_PLA: begin sp++; a = s1; p = nz(p, a); end
                OP_PLP: begin sp++; p = (s1 & ~P_B) | P_U; end
                OP_AND: begin a = a & m; p = nz(p, a); end
                OP_EOR: begin a = a ^ m; p = nz(p, a); end
                OP_ORA: begin a = a | m; p = nz(p, a); end
                OP_BIT: p = (p & ~(P_Z | P_N | P_V)) | (m & (P_N | P_V))
                            | (((m & a) == 0) ? P_Z : 8'h00);
                OP_ADC, OP_SBC: begin
                    v = (act == OP_SBC) ? ~m : m;
                    sum = a + v + p[0]; r = sum[7:0];
                    p = sum[8] ? (p | P_C) : (p & ~P_C);
                    p = ((~(a ^ v) & (a ^ r) & 8'h80) != 0) ? (p | P_V) : (p & ~P_V);
                    a = r; p = nz(p, a);
                end
                OP_CMP: p = cmpf(p, a, m);
                OP_CPX: p = cmpf(p, x, m);
                OP_CPY: p = cmpf(p, y, m);
                OP_INC, OP_DEC: begin
                    r = (act == OP_INC) ? m + 1 : m - 1;
                    wa[n] = ea; wd[n] = r; n++; p = nz(p, r);
                end
                OP_INX: begin x++; p = nz(p, x); end
                OP_INY: begin y++; p = nz(p, y); end
                OP_DEX: begin x--; p = nz(p, x); end
                OP_DEY: begin y--; p = nz(p, y); end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                    v = (mode == MODE_ACC) ? a : m;
                    case (act)
                        OP_ASL: r = v << 1;
                        OP_LSR: r = v >> 1;
                        OP_ROL: r = {v[6:0], p[0]};
                        default: r = {p[0], v[7:1]};
                    endcase
                    p[0] = (act == OP_ASL || act == OP_ROL) ? v[7] : v[0];
                    if (mode == MODE_ACC) a = r;
                    else begin wa[n] = ea; wd[n] = r; n++; end
                    p = nz(p, r);
                end
                OP_JMP: pc = ea;
                OP_JSR: begin
                    ret = pc - 1;
                    wa[n] = {8'h01, sp}; wd[n] = ret[15:8]; n++; sp--;
                    wa[n] = {8'h01, sp}; wd[n] = ret[7:0]; n++; sp--;
                    pc = ea;
                end
                OP_RTS: begin sp += 2; pc = {s2, s1} + 1; end
                OP_BCC: take = !p[0];
                OP_BCS: take = p[0];
                OP_BEQ: take = p[1];
                OP_BNE: take = !p[1];
                OP_BMI: take = p[7];
                OP_BPL: take = !p[7];
                OP_BVS: take = p[6];
                OP_BVC: take = !p[6];
                OP_CLC: p = p & ~P_C;
                OP_CLD: p = p & ~P_D;
                OP_CLI: p = p & ~P_I;
                OP_CLV: p = p & ~P_V;
                OP_SEC: p = p | P_C;
                OP_SED: p = p | P_D;
                OP_SEI: p = p | P_I;
                OP_BRK: begin
                    ret = pc + 1;
                    wa[n] = {8'h01, sp}; wd[n] = ret[15:8]; n++; sp--;
                    wa[n] = {8'h01, sp}; wd[n] = ret[7:0]; n++; sp--;
                    wa[n] = {8'h01, sp}; wd[n] = p | P_B | P_U; n++; sp--;
                    p = p | P_I; pc = vec;
                end
                OP_RTI: begin sp += 3; p = (s1 & ~P_B) | P_U; pc = {s3, s2}; end
                default: ;
            endcase
            if (take) pc = pc + {{8{m[7]}}, m};
        end
        for (k = 0; k < ((n > 0) ? n : 1); k++) begin
            e.wv = (k < n); e.wa = (k < n) ? wa[k] : 16'h0;
            e.wd = (k < n) ? wd[k] : 8'h0;
            e.last = (k == ((n > 0) ? n : 1) - 1);
            e.pc = pc; e.a = a; e.x = x; e.y = y; e.sp = sp; e.p = p; e.fault = bad;
            pending.push_back(e);
        end
    endfunction

    // Compares one output transaction with the oldest expectation
    function void check_result(logic [OutBits-1:0] d, logic tl);
        exec_result_t got, exp_r;
        got = '{d[0], d[16:1], d[24:17], tl, d[40:25], d[48:41], d[56:49],
                d[64:57], d[72:65], d[80:73], d[81]};
        if (pending.size() == 0) begin
            $display("%0t: unexpected transaction %h", $time, got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
            errors++;
        end
    endfunction
endclass

module tb_cpu_6502_instruction_execute_top;
    logic aclk, aresetn;
    logic s_axis_tvalid, s_axis_tready;
    logic [InBits-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [OutBits-1:0] m_axis_tdata;

    exec_scoreboard sb;
    int send_idle, recv_stall;
    bit hold_off;

    cpu_6502_instruction_execute_top uut (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end

    // Sends one instruction, with a random gap first
    task automatic send_instr(logic [5:0] act, logic [3:0] mode);
        logic [InBits-1:0] d;
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        d = {$urandom, $urandom, $urandom};
        d[5:0] = act; d[9:6] = mode; d[InBits-1:90] = '0;
        s_axis_tvalid <= 1; s_axis_tdata <= d;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_instruction(d);
    endtask

    // Mostly legal modes, sometimes any code
    task automatic send_random();
        logic [5:0] act; logic [3:0] mode; logic [15:0] mm;
        act = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(55));
        mm = sb.mode_mask(act);
        mode = 4'($urandom_range(15));
        if (mm != 0 && $urandom_range(9) != 0)
            while (!mm[mode]) mode = 4'($urandom_range(15));
        send_instr(act, mode);
    endtask

    initial begin
        int i, ph;
        sb = new();
        aresetn = 0; s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
        send_idle = 0; recv_stall = 0; hold_off = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // Directed: pushes, pulls, calls, BRK, accumulator shift, bad modes
        send_instr(OP_LDA, 0); send_instr(OP_ADC, 0); send_instr(OP_SBC, 1);
        send_instr(OP_PHA, 11); send_instr(OP_PHP, 15); send_instr(OP_PLA, 11);
        send_instr(OP_PLP, 0); send_instr(OP_JSR, 4); send_instr(OP_RTS, 11);
        send_instr(OP_BRK, 11); send_instr(OP_RTI, 11); send_instr(OP_ASL, MODE_ACC);
        send_instr(OP_ROR, 1); send_instr(OP_LDA, 13); send_instr(6'd60, 0);
        send_instr(OP_TXS, 11); send_instr(OP_SED, 11); send_instr(OP_ADC, 0);
        send_instr(OP_BNE, 10); send_instr(OP_BEQ, 10); send_instr(OP_JMP, 7);
        send_instr(OP_STA, 8); send_instr(OP_INC, 4); send_instr(OP_BIT, 1);
        // Long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (200) @(posedge aclk);
                hold_off = 0;
            end
            for (i = 0; i < 8; i++) send_instr(OP_BRK, 11);
        join
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 49; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 49; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            for (i = 0; i < 22; i++) send_random();
        end
        s_axis_tvalid <= 0;
        recv_stall = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/c6502x_pkg.sv
rtl/core/c6502x_alu.sv
rtl/core/c6502x_out.sv
rtl/core/cpu_6502_instruction_execute_top.sv
rtl/core/c6502x_chk.sv
tb/sv/tb_cpu_6502_instruction_execute_top.sv
